/* hw/rtl/nha_pkg.sv */
// Shared types and constants for the node hash accumulator.
`timescale 1ns / 1ps

package nha_pkg;

  localparam logic [63:0] MixMul    = 64'h0e98_46af_9b1a_615d;
  localparam logic [63:0] GoldenAdd = 64'h0000_0000_9e37_79b9;

  typedef enum logic [1:0] {
    OpBegin   = 2'd0,
    OpOrdered = 2'd1,
    OpCommut  = 2'd2,
    OpParent  = 2'd3
  } op_e;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] y;
  } mix_rsp_t;

endpackage

/* hw/rtl/node_hash_accumulator_core.sv */
// Top level of the node hash accumulator: sequencer, hash state and output register.
//
// Input channel (in_valid_i / in_ready_o) carries one request: op_i, value_i,
// oper_index_i, last_i. Output channel (out_valid_o / out_ready_i) carries hash_o,
// produced only for requests with last_i set.
// One request is in flight at a time; in_ready_o is low while it is worked on.
// A begin request needs no mix, an ordered or commutative child one, a parent two.
// Each 64-bit mix is two 64-bit multiplies, each as three passes through the one
// shared 32x32 multiplier plus a fold step.
// A last request's hash is registered into the output register when it commits.
// The output register holds one hash; a stalled receiver holds the block only
// when a new last request finishes while the previous hash is still waiting.
// Reset clears the running hash, the base seed and the output valid.
`timescale 1ns / 1ps

module node_hash_accumulator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] value_i,
  input  logic [63:0] oper_index_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMix1 = 2'd1;
  localparam logic [1:0] StMix2 = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]        state_q, state_d;
  nha_pkg::op_e      op_q, op_d;
  logic              last_q, last_d;
  logic [63:0]       idx_q, idx_d;
  logic [63:0]       res_q, res_d;
  logic [63:0]       run_q, run_d;
  logic [63:0]       base_q, base_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       hash_q, hash_d;
  logic              accept;
  logic              commit;
  logic [63:0]       seed_sel;
  nha_pkg::op_e      op_in;
  nha_pkg::mix_req_t mix_req;
  nha_pkg::mix_rsp_t mix_rsp;

  nha_mixer u_mixer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mix_req),
    .rsp_o  (mix_rsp)
  );

  assign op_in      = nha_pkg::op_e'(op_i);
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == StFin) && (!last_q || !out_valid_q || out_ready_i);
  assign seed_sel   = (op_in == nha_pkg::OpOrdered) ? run_q : base_q;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    last_d        = last_q;
    idx_d         = idx_q;
    res_d         = res_q;
    run_d         = run_q;
    base_d        = base_q;
    hash_d        = hash_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    mix_req.start = 1'b0;
    mix_req.x     = seed_sel + nha_pkg::GoldenAdd + value_i;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d   = op_in;
          last_d = last_i;
          idx_d  = oper_index_i;
          if (op_in == nha_pkg::OpBegin) begin
            res_d   = value_i;
            state_d = StFin;
          end else begin
            mix_req.start = 1'b1;
            state_d       = StMix1;
          end
        end
      end
      StMix1: begin
        if (mix_rsp.done) begin
          if (op_q == nha_pkg::OpParent) begin
            mix_req.start = 1'b1;
            mix_req.x     = mix_rsp.y + nha_pkg::GoldenAdd + idx_q;
            state_d       = StMix2;
          end else begin
            res_d   = (op_q == nha_pkg::OpOrdered) ? mix_rsp.y : run_q + mix_rsp.y;
            state_d = StFin;
          end
        end
      end
      StMix2: begin
        if (mix_rsp.done) begin
          res_d   = run_q + mix_rsp.y;
          state_d = StFin;
        end
      end
      StFin: begin
        if (commit) begin
          run_d = res_q;
          if (op_q == nha_pkg::OpBegin) begin
            base_d = res_q;
          end
          if (last_q) begin
            hash_d      = res_q;
            out_valid_d = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      run_q       <= 64'd0;
      base_q      <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    last_q <= last_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    hash_q <= hash_d;
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

endmodule

/* hw/rtl/nha_mul32.sv */
// Shared 32x32 multiplier with registered 64-bit product.
`timescale 1ns / 1ps

module nha_mul32 (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/nha_mixer.sv */
// 64-bit xor-shift/multiply mixer built on one shared 32x32 multiplier.
`timescale 1ns / 1ps

module nha_mixer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nha_pkg::mix_req_t req_i,
  output nha_pkg::mix_rsp_t rsp_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StM0   = 3'd1;
  localparam logic [2:0] StM1   = 3'd2;
  localparam logic [2:0] StM2   = 3'd3;
  localparam logic [2:0] StM3   = 3'd4;

  localparam logic [31:0] CLo = nha_pkg::MixMul[31:0];
  localparam logic [31:0] CHi = nha_pkg::MixMul[63:32];

  logic [2:0]  state_q, state_d;
  logic        round_q, round_d;
  logic        done_q, done_d;
  logic [63:0] a_q, a_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] y_q, y_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] acc_fin;

  nha_mul32 u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // low 64 bits of a * c = aL*cL + ((aH*cL + aL*cH) << 32)
  assign acc_fin = acc_q + {prod[31:0], 32'd0};

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    done_d  = 1'b0;
    a_d     = a_q;
    acc_d   = acc_q;
    y_d     = y_q;
    mul_a   = a_q[31:0];
    mul_b   = CLo;
    unique case (state_q)
      StIdle: begin
        if (req_i.start) begin
          a_d     = req_i.x ^ (req_i.x >> 32);
          round_d = 1'b0;
          state_d = StM0;
        end
      end
      StM0: begin
        state_d = StM1;
      end
      StM1: begin
        mul_a   = a_q[63:32];
        acc_d   = prod;
        state_d = StM2;
      end
      StM2: begin
        mul_b   = CHi;
        acc_d   = acc_fin;
        state_d = StM3;
      end
      StM3: begin
        if (!round_q) begin
          a_d     = acc_fin ^ (acc_fin >> 32);
          round_d = 1'b1;
          state_d = StM0;
        end else begin
          y_d     = acc_fin ^ (acc_fin >> 28);
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    y_q   <= y_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = y_q;

endmodule

/* hw/rtl/nha_checker.sv */
// Port-level assertions for the node hash accumulator, bound to the top level.
`timescale 1ns / 1ps

module nha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  op_i,
  input logic [63:0] value_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_o
);

  // stalled hash holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_o))
    else $error("hash changed while stalled");

  // one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready while busy");

  // begin marked last returns its seed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == nha_pkg::OpBegin) && last_i && !out_valid_o
    |-> ##2 out_valid_o && (hash_o == $past(value_i, 2)))
    else $error("begin hash mismatch");

  // a new hash only appears after a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("hash without request");

endmodule

bind node_hash_accumulator_core nha_checker u_nha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .value_i     (value_i),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hash_o      (hash_o)
);
